### sv/rdma_send_queue_sequencer_assert.svh
// Assertion macros for the send queue sequencer.
// Included by the files that carry concurrent checks; no other dependencies.
`ifndef RDMA_SEND_QUEUE_SEQUENCER_ASSERT_SVH
`define RDMA_SEND_QUEUE_SEQUENCER_ASSERT_SVH

`ifndef SYNTH
`define RSQS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define RSQS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define RSQS_ASSERT(lbl, clk, rst_n, prop, msg)
`define RSQS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

### sv/rsqs_pkg.sv
// Shared types, codes and constants of the send queue sequencer.
// No dependencies; imported by every module of the block.
package rsqs_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int CHUNK_LOG2_DEF  = 30;
    localparam int SIZE_BITS_DEF   = 36;

    localparam int ADDR_W  = 64;
    localparam int KEY_W   = 32;
    localparam int LEN_W   = 37;
    localparam int PEND_W  = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [2:0] {
        FUNC_INSERT     = 3'd0,
        FUNC_REPLY      = 3'd1,
        FUNC_REFUSE     = 3'd2,
        FUNC_WRITE_DONE = 3'd3,
        FUNC_CLOSE_DONE = 3'd4,
        FUNC_FAIL_DONE  = 3'd5,
        FUNC_OPEN_DONE  = 3'd6
    } t_func;

    typedef enum logic [2:0] {
        CMD_OPEN_SEND  = 3'd0,
        CMD_WRITE      = 3'd1,
        CMD_CLOSE_SEND = 3'd2,
        CMD_FAIL_SEND  = 3'd3,
        CMD_ITEM_DONE  = 3'd4,
        CMD_ERROR      = 3'd5
    } t_cmd;

    typedef enum logic [2:0] {
        ERR_NONE      = 3'd0,
        ERR_EMPTY     = 3'd1,
        ERR_PHASE     = 3'd2,
        ERR_TOO_LARGE = 3'd3,
        ERR_FULL      = 3'd4
    } t_err;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PEER_RANK   = 2'd0,
        CFG_MESSAGE_TAG = 2'd1
    } t_cfg_idx;

    typedef enum logic [4:0] {
        PH_WAIT  = 5'b00001,
        PH_SEND  = 5'b00010,
        PH_RDMA  = 5'b00100,
        PH_CLOSE = 5'b01000,
        PH_FAIL  = 5'b10000
    } t_phase;

    typedef enum logic [10:0] {
        S_IDLE   = 11'b00000000001,
        S_READ   = 11'b00000000010,
        S_EVAL   = 11'b00000000100,
        S_CMP    = 11'b00000001000,
        S_WR     = 11'b00000010000,
        S_ADV_L  = 11'b00000100000,
        S_ADV_R  = 11'b00001000000,
        S_ADV_N  = 11'b00010000000,
        S_DONE   = 11'b00100000000,
        S_REREAD = 11'b01000000000,
        S_OPEN   = 11'b10000000000
    } t_state;

    typedef enum logic {
        ALU_ADD = 1'b0,
        ALU_SUB = 1'b1
    } t_alu_op;

    typedef struct packed {
        logic [2:0]        func;
        logic [ADDR_W-1:0] buffer_addr;
        logic [KEY_W-1:0]  buffer_key;
        logic [LEN_W-1:0]  buffer_size;
        logic [ADDR_W-1:0] peer_addr;
        logic [ADDR_W-1:0] peer_size;
        logic [KEY_W-1:0]  peer_key;
        logic              region_ok;
    } t_in_req;

    typedef struct packed {
        logic [2:0]        command;
        logic [LEN_W-1:0]  length;
        logic [ADDR_W-1:0] loc_addr;
        logic [KEY_W-1:0]  loc_key;
        logic [ADDR_W-1:0] rem_addr;
        logic [KEY_W-1:0]  rem_key;
        logic              success;
        logic [2:0]        error_code;
        logic              last;
    } t_out_res;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [KEY_W-1:0]  key;
        logic [LEN_W-1:0]  size;
    } t_entry;

    typedef struct packed {
        logic push;
        logic pop;
    } t_q_ctl;

    function automatic t_out_res mk_err(input t_err code);
        t_out_res r;
        r            = '0;
        r.command    = CMD_ERROR;
        r.error_code = code;
        r.last       = 1'b1;
        return r;
    endfunction

    function automatic t_out_res mk_ctl(input t_cmd cmd, input logic ok, input logic last);
        t_out_res r;
        r         = '0;
        r.command = cmd;
        r.success = ok;
        r.last    = last;
        return r;
    endfunction

endpackage

### sv/rsqs_alu.sv
// Shared 64-bit add/subtract unit with borrow out.
// Depends on rsqs_pkg for the operation code.
module rsqs_alu import rsqs_pkg::*; (
    input  t_alu_op           i_op,
    input  logic [ADDR_W-1:0] i_a,
    input  logic [ADDR_W-1:0] i_b,
    output logic [ADDR_W-1:0] o_res,
    output logic              o_borrow
);

    logic [ADDR_W:0] wide;

    always_comb begin
        if (i_op == ALU_SUB) begin
            wide = {1'b0, i_a} - {1'b0, i_b};
        end else begin
            wide = {1'b0, i_a} + {1'b0, i_b};
        end
    end

    assign o_res    = wide[ADDR_W-1:0];
    assign o_borrow = (i_op == ALU_SUB) && wide[ADDR_W];

endmodule

### sv/rsqs_queue.sv
// Circular buffer of pending send buffers with registered head read.
// Depends on rsqs_pkg for the entry and control types.
module rsqs_queue import rsqs_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH_DEF,
    localparam int PTR_W = $clog2(DEPTH),
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_q_ctl           i_ctl,
    input  t_entry           i_entry,
    output t_entry           o_head,
    output logic [CNT_W-1:0] o_count
);

    t_entry           mem [DEPTH];
    logic [PTR_W-1:0] r_head, n_head;
    logic [PTR_W-1:0] r_tail, n_tail;
    logic [CNT_W-1:0] r_count, n_count;
    t_entry           r_rd;

    function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_comb begin
        n_head  = r_head;
        n_tail  = r_tail;
        n_count = r_count;
        if (i_ctl.push) begin
            n_tail  = wrap_inc(r_tail);
            n_count = n_count + 1'b1;
        end
        if (i_ctl.pop) begin
            n_head  = wrap_inc(r_head);
            n_count = n_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            mem[r_tail] <= i_entry;
        end
        r_rd <= mem[r_head];
    end

    assign o_head  = r_rd;
    assign o_count = r_count;

endmodule

### sv/rdma_send_queue_sequencer.sv
// Send queue sequencer top level: request sequencer, output register, config.
// Depends on rsqs_pkg, rsqs_queue, rsqs_alu and the assertion macro header.
//
// One request is handled at a time; o_in_ready is high only while the
// sequencer is idle. A request passes S_READ and ends in S_EVAL when it gives
// no result or one result; an insert that opens the new head goes on through
// S_REREAD and S_OPEN. A completion (refusal, close done, fail done) goes on to
// S_DONE, then through S_REREAD and S_OPEN when it opens the next queued buffer.
// A peer open reply goes on to the size compare in S_CMP, where a size or region
// failure ends it; each write chunk but the last then takes S_WR and three
// passes through the single shared 64-bit adder (local address, remote address,
// remaining bytes), and the last chunk takes S_WR alone. Queue reads go through a
// registered memory port, so a read state comes before each use of the head.
// A full output register that is not taken stalls the states that load it.
`include "rdma_send_queue_sequencer_assert.svh"

module rdma_send_queue_sequencer import rsqs_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int CHUNK_LOG2  = CHUNK_LOG2_DEF,
    parameter int SIZE_BITS   = SIZE_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_req               i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_res              o_out_data,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [ADDR_W-1:0] CHUNK      = ADDR_W'(1) << CHUNK_LOG2;
    localparam logic [ADDR_W-1:0] SIZE_LIMIT = ADDR_W'(1) << SIZE_BITS;

    t_state            r_state, n_state;
    t_phase            r_phase, n_phase;
    t_in_req           r_req, n_req;
    logic [PEND_W-1:0] r_pend, n_pend;
    logic [PEND_W-1:0] r_cnt, n_cnt;
    logic [ADDR_W-1:0] r_la, n_la;
    logic [ADDR_W-1:0] r_ra, n_ra;
    logic [LEN_W-1:0]  r_left, n_left;
    logic              r_out_valid, n_out_valid;
    t_out_res          r_out, n_out;
    logic [15:0]       r_peer_rank;
    logic [31:0]       r_message_tag;

    t_q_ctl            q_ctl;
    t_entry            q_entry;
    t_entry            q_head;
    logic [CNT_W-1:0]  q_count;
    logic              q_full;

    t_alu_op           alu_op;
    logic [ADDR_W-1:0] alu_a, alu_b, alu_res;
    logic              alu_borrow;

    logic              slot_free;
    logic              out_load;
    t_out_res          res;
    logic              too_big;
    logic              fin;
    logic [PEND_W-1:0] pend_dec;
    t_phase            want;

    rsqs_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (q_ctl),
        .i_entry (q_entry),
        .o_head  (q_head),
        .o_count (q_count)
    );

    rsqs_alu u_alu (
        .i_op     (alu_op),
        .i_a      (alu_a),
        .i_b      (alu_b),
        .o_res    (alu_res),
        .o_borrow (alu_borrow)
    );

    assign q_entry.addr = r_req.buffer_addr;
    assign q_entry.key  = r_req.buffer_key;
    assign q_entry.size = r_req.buffer_size;
    assign q_full   = (q_count == CNT_W'(QUEUE_DEPTH));
    assign too_big  = ADDR_W'(r_req.buffer_size) > SIZE_LIMIT;
    assign fin      = ADDR_W'(r_left) <= CHUNK;
    assign pend_dec = (r_pend != '0) ? r_pend - 1'b1 : '0;
    assign slot_free = !r_out_valid || i_out_ready;

    always_comb begin
        case (r_req.func)
            FUNC_REFUSE:     want = PH_SEND;
            FUNC_CLOSE_DONE: want = PH_CLOSE;
            default:         want = PH_FAIL;
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_req       = r_req;
        n_pend      = r_pend;
        n_cnt       = r_cnt;
        n_la        = r_la;
        n_ra        = r_ra;
        n_left      = r_left;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        q_ctl       = '0;
        out_load    = 1'b0;
        res         = '0;
        alu_op      = ALU_ADD;
        alu_a       = r_la;
        alu_b       = CHUNK;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_req   = i_in_data;
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = S_EVAL;
            end
            S_EVAL: begin
                case (r_req.func)
                    FUNC_INSERT: begin
                        if (q_full || too_big) begin
                            if (slot_free) begin
                                out_load = 1'b1;
                                res      = mk_err(q_full ? ERR_FULL : ERR_TOO_LARGE);
                                n_state  = S_IDLE;
                            end
                        end else begin
                            q_ctl.push = 1'b1;
                            n_state = (q_count == '0 && r_phase == PH_WAIT) ? S_REREAD : S_IDLE;
                        end
                    end
                    FUNC_REPLY, FUNC_REFUSE, FUNC_CLOSE_DONE, FUNC_FAIL_DONE: begin
                        if (q_count == '0) begin
                            if (slot_free) begin
                                out_load = 1'b1;
                                res      = mk_err(ERR_EMPTY);
                                n_state  = S_IDLE;
                            end
                        end else if (r_phase != ((r_req.func == FUNC_REPLY) ? PH_SEND : want)) begin
                            if (slot_free) begin
                                out_load = 1'b1;
                                res      = mk_err(ERR_PHASE);
                                n_state  = S_IDLE;
                            end
                        end else begin
                            n_state = (r_req.func == FUNC_REPLY) ? S_CMP : S_DONE;
                        end
                    end
                    FUNC_WRITE_DONE: begin
                        if (r_phase != PH_RDMA) begin
                            if (slot_free) begin
                                out_load = 1'b1;
                                res      = mk_err(ERR_PHASE);
                                n_state  = S_IDLE;
                            end
                        end else if (pend_dec == '0) begin
                            if (slot_free) begin
                                out_load = 1'b1;
                                res      = mk_ctl(CMD_CLOSE_SEND, 1'b0, 1'b1);
                                n_phase  = PH_CLOSE;
                                n_pend   = '0;
                                n_state  = S_IDLE;
                            end
                        end else begin
                            n_pend  = pend_dec;
                            n_state = S_IDLE;
                        end
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_CMP: begin
                alu_op = ALU_SUB;
                alu_a  = r_req.peer_size;
                alu_b  = ADDR_W'(q_head.size);
                if (alu_borrow || !r_req.region_ok) begin
                    if (slot_free) begin
                        out_load = 1'b1;
                        n_state  = S_IDLE;
                        if (alu_borrow) begin
                            res = mk_err(ERR_TOO_LARGE);
                        end else begin
                            res     = mk_ctl(CMD_FAIL_SEND, 1'b0, 1'b1);
                            n_phase = PH_FAIL;
                        end
                    end
                end else begin
                    n_la    = q_head.addr;
                    n_ra    = r_req.peer_addr;
                    n_left  = q_head.size;
                    n_cnt   = '0;
                    n_state = S_WR;
                end
            end
            S_WR: begin
                if (slot_free) begin
                    out_load     = 1'b1;
                    res.command  = CMD_WRITE;
                    res.length   = fin ? r_left : CHUNK[LEN_W-1:0];
                    res.loc_addr = r_la;
                    res.loc_key  = q_head.key;
                    res.rem_addr = r_ra;
                    res.rem_key  = r_req.peer_key;
                    res.last     = fin;
                    n_cnt        = r_cnt + 1'b1;
                    if (fin) begin
                        n_pend  = r_cnt + 1'b1;
                        n_phase = PH_RDMA;
                        n_state = S_IDLE;
                    end else begin
                        n_state = S_ADV_L;
                    end
                end
            end
            S_ADV_L: begin
                n_la    = alu_res;
                n_state = S_ADV_R;
            end
            S_ADV_R: begin
                alu_a   = r_ra;
                n_ra    = alu_res;
                n_state = S_ADV_N;
            end
            S_ADV_N: begin
                alu_op  = ALU_SUB;
                alu_a   = ADDR_W'(r_left);
                n_left  = alu_res[LEN_W-1:0];
                n_state = S_WR;
            end
            S_DONE: begin
                if (slot_free) begin
                    out_load  = 1'b1;
                    res       = mk_ctl(CMD_ITEM_DONE, r_req.func == FUNC_CLOSE_DONE,
                                       q_count == CNT_W'(1));
                    q_ctl.pop = 1'b1;
                    n_phase   = PH_WAIT;
                    n_state   = (q_count == CNT_W'(1)) ? S_IDLE : S_REREAD;
                end
            end
            S_REREAD: begin
                n_state = S_OPEN;
            end
            S_OPEN: begin
                if (slot_free) begin
                    out_load   = 1'b1;
                    res        = mk_ctl(CMD_OPEN_SEND, 1'b0, 1'b1);
                    res.length = q_head.size;
                    n_phase    = PH_SEND;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (out_load) begin
            n_out_valid = 1'b1;
            n_out       = res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_phase       <= PH_WAIT;
            r_pend        <= '0;
            r_out_valid   <= 1'b0;
            r_peer_rank   <= '0;
            r_message_tag <= '0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
            if (i_cfg_we && i_cfg_index == CFG_PEER_RANK) begin
                r_peer_rank <= i_cfg_data[15:0];
            end
            if (i_cfg_we && i_cfg_index == CFG_MESSAGE_TAG) begin
                r_message_tag <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_req  <= n_req;
        r_cnt  <= n_cnt;
        r_la   <= n_la;
        r_ra   <= n_ra;
        r_left <= n_left;
        r_out  <= n_out;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // busy phase always has a head entry
    `RSQS_ASSERT(a_phase_has_entry, i_clk, i_rst_n, (r_phase != PH_WAIT) |-> (q_count != '0), "phase active with empty queue")
    `RSQS_ASSERT(a_open_has_entry, i_clk, i_rst_n, (r_state == S_OPEN) |-> (q_count != '0), "open request with empty queue")
    `RSQS_ASSERT(a_chunk_len, i_clk, i_rst_n, (out_load && res.command == CMD_WRITE) |-> (ADDR_W'(res.length) <= CHUNK), "write longer than chunk")
    `RSQS_ASSERT_NEXT(a_pop_reopens, i_clk, i_rst_n, q_ctl.pop && (q_count != CNT_W'(1)), r_state == S_REREAD, "next buffer not opened after completion")

endmodule

### tb/rsqs_command_monitor.sv
`timescale 1ns / 100ps
// Command monitor for the send queue sequencer: predicts the commands of every
// accepted request and compares them with the accepted results, field by field.
// Depends on rsqs_pkg only.
module rsqs_command_monitor import rsqs_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  t_in_req               i_in_data,
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  t_out_res              i_out_data,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_pending,
    output int                    o_fail_count,
    output t_phase                o_phase,
    output logic [4:0]            o_entries,
    output logic [LEN_W-1:0]      o_head_len
);

    localparam int DEPTH = QUEUE_DEPTH_DEF;
    localparam logic [LEN_W-1:0] CHUNK_BYTES = LEN_W'(1) << CHUNK_LOG2_DEF;
    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(1) << SIZE_BITS_DEF;

    logic [ADDR_W-1:0] buf_addr [DEPTH];
    logic [KEY_W-1:0]  buf_key  [DEPTH];
    logic [LEN_W-1:0]  buf_len  [DEPTH];
    logic [3:0]        head_idx;
    logic [3:0]        tail_idx;
    logic [4:0]        entries;
    t_phase            phase;
    logic [PEND_W-1:0] writes_left;
    logic [15:0]       peer_rank;
    logic [31:0]       msg_tag;

    t_out_res expected_cmds[$];
    t_out_res request_cmds[$];

    function automatic t_out_res blank_cmd(input t_cmd cmd);
        t_out_res r;
        r = '0;
        r.command = cmd;
        return r;
    endfunction

    task automatic push_error(input t_err code);
        t_out_res r;
        r = blank_cmd(CMD_ERROR);
        r.error_code = code;
        request_cmds.push_back(r);
    endtask

    task automatic open_head();
        t_out_res r;
        if (entries != 0) begin
            r = blank_cmd(CMD_OPEN_SEND);
            r.length = buf_len[head_idx];
            request_cmds.push_back(r);
            phase = PH_SEND;
        end
    endtask

    task automatic retire_head(input logic ok);
        t_out_res r;
        r = blank_cmd(CMD_ITEM_DONE);
        r.success = ok;
        request_cmds.push_back(r);
        head_idx = head_idx + 1'b1;
        entries = entries - 1'b1;
        phase = PH_WAIT;
        open_head();
    endtask

    task automatic split_writes(input t_in_req req);
        t_out_res r;
        logic [ADDR_W-1:0] la;
        logic [ADDR_W-1:0] ra;
        logic [LEN_W-1:0] left;
        la = buf_addr[head_idx];
        ra = req.peer_addr;
        left = buf_len[head_idx];
        r = blank_cmd(CMD_WRITE);
        r.loc_key = buf_key[head_idx];
        r.rem_key = req.peer_key;
        do begin
            r.length = (left > CHUNK_BYTES) ? CHUNK_BYTES : left;
            r.loc_addr = la;
            r.rem_addr = ra;
            request_cmds.push_back(r);
            la = la + r.length;
            ra = ra + r.length;
            left = left - r.length;
        end while (left != 0);
        writes_left = PEND_W'(request_cmds.size());
        phase = PH_RDMA;
    endtask

    task automatic step_sequencer(input t_in_req req);
        t_phase want;
        t_out_res r;
        request_cmds.delete();
        case (req.func)
            FUNC_INSERT: begin
                if (entries >= DEPTH) begin
                    push_error(ERR_FULL);
                end else if (req.buffer_size > MAX_LEN) begin
                    push_error(ERR_TOO_LARGE);
                end else begin
                    buf_addr[tail_idx] = req.buffer_addr;
                    buf_key[tail_idx] = req.buffer_key;
                    buf_len[tail_idx] = req.buffer_size;
                    tail_idx = tail_idx + 1'b1;
                    entries = entries + 1'b1;
                    if (entries == 1 && phase == PH_WAIT) open_head();
                end
            end
            FUNC_REPLY: begin
                if (entries == 0) begin
                    push_error(ERR_EMPTY);
                end else if (phase != PH_SEND) begin
                    push_error(ERR_PHASE);
                end else if (buf_len[head_idx] > req.peer_size) begin
                    push_error(ERR_TOO_LARGE);
                end else if (!req.region_ok) begin
                    request_cmds.push_back(blank_cmd(CMD_FAIL_SEND));
                    phase = PH_FAIL;
                end else begin
                    split_writes(req);
                end
            end
            FUNC_REFUSE, FUNC_CLOSE_DONE, FUNC_FAIL_DONE: begin
                want = (req.func == FUNC_REFUSE) ? PH_SEND :
                       (req.func == FUNC_CLOSE_DONE) ? PH_CLOSE : PH_FAIL;
                if (entries == 0) push_error(ERR_EMPTY);
                else if (phase != want) push_error(ERR_PHASE);
                else retire_head(req.func == FUNC_CLOSE_DONE);
            end
            FUNC_WRITE_DONE: begin
                if (phase != PH_RDMA) begin
                    push_error(ERR_PHASE);
                end else begin
                    if (writes_left != 0) writes_left = writes_left - 1'b1;
                    if (writes_left == 0) begin
                        request_cmds.push_back(blank_cmd(CMD_CLOSE_SEND));
                        phase = PH_CLOSE;
                    end
                end
            end
            default: ;
        endcase
        if (request_cmds.size() != 0) begin
            r = request_cmds.pop_back();
            r.last = 1'b1;
            request_cmds.push_back(r);
        end
        foreach (request_cmds[i]) expected_cmds.push_back(request_cmds[i]);
    endtask

    function automatic bit field_differs(input string name, input logic [ADDR_W-1:0] want,
                                         input logic [ADDR_W-1:0] got);
        if (want !== got) begin
            $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    always @(posedge i_clk) begin : monitor_tick
        t_out_res want;
        bit bad;
        if (!i_rst_n) begin
            head_idx = '0;
            tail_idx = '0;
            entries = '0;
            phase = PH_WAIT;
            writes_left = '0;
            peer_rank = '0;
            msg_tag = '0;
            expected_cmds.delete();
            o_fail_count = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_PEER_RANK:   peer_rank = i_cfg_data[15:0];
                    CFG_MESSAGE_TAG: msg_tag = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_cmds.size() == 0) begin
                    $display("%0t ns: unexpected result, expected none, actual %h",
                             $time, i_out_data);
                    o_fail_count = o_fail_count + 1;
                end else begin
                    want = expected_cmds.pop_front();
                    bad = 1'b0;
                    bad |= field_differs("command", want.command, i_out_data.command);
                    bad |= field_differs("length", want.length, i_out_data.length);
                    bad |= field_differs("loc_addr", want.loc_addr, i_out_data.loc_addr);
                    bad |= field_differs("loc_key", want.loc_key, i_out_data.loc_key);
                    bad |= field_differs("rem_addr", want.rem_addr, i_out_data.rem_addr);
                    bad |= field_differs("rem_key", want.rem_key, i_out_data.rem_key);
                    bad |= field_differs("success", want.success, i_out_data.success);
                    bad |= field_differs("error_code", want.error_code, i_out_data.error_code);
                    bad |= field_differs("last", want.last, i_out_data.last);
                    if (bad) o_fail_count = o_fail_count + 1;
                end
            end
            if (i_in_valid && i_in_ready) step_sequencer(i_in_data);
        end
        o_pending = expected_cmds.size();
        o_phase = phase;
        o_entries = entries;
        o_head_len = buf_len[head_idx];
    end

endmodule

### tb/tb.sv
`timescale 1ns / 100ps
// Top of the send queue sequencer testbench: clock, reset, request stimulus,
// register writes and verdict. Depends on rsqs_pkg, rdma_send_queue_sequencer and rsqs_command_monitor.
module tb;
    import rsqs_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int RANDOM_ITEMS = 430;
    localparam logic [2:0] FUNC_UNUSED = 3'd7;
    localparam logic [LEN_W-1:0] CHUNK = LEN_W'(1) << CHUNK_LOG2_DEF;
    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(1) << SIZE_BITS_DEF;
    localparam logic [ADDR_W-1:0] ALL_ONES = '1;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_ready;
    t_in_req               i_in_data;
    logic                  o_out_valid;
    logic                  i_out_ready;
    t_out_res              o_out_data;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    int                    pending;
    int                    fail_count;
    t_phase                mon_phase;
    logic [4:0]            mon_entries;
    logic [LEN_W-1:0]      head_len;

    int snd_idle_pct;
    int rcv_idle_pct;
    int idle_cycles;
    int burst_left;
    int sent;

    rdma_send_queue_sequencer DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    rsqs_command_monitor u_cmd_mon (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_in_data    (i_in_data),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_out_data   (o_out_data),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_pending    (pending),
        .o_fail_count (fail_count),
        .o_phase      (mon_phase),
        .o_entries    (mon_entries),
        .o_head_len   (head_len)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= rcv_idle_pct);
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic logic [ADDR_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic t_in_req req_of(input logic [2:0] func, input logic [ADDR_W-1:0] baddr,
                                       input logic [KEY_W-1:0] bkey,
                                       input logic [LEN_W-1:0] blen,
                                       input logic [ADDR_W-1:0] paddr,
                                       input logic [ADDR_W-1:0] psize,
                                       input logic [KEY_W-1:0] pkey, input logic ok);
        t_in_req r;
        r.func = func;
        r.buffer_addr = baddr;
        r.buffer_key = bkey;
        r.buffer_size = blen;
        r.peer_addr = paddr;
        r.peer_size = psize;
        r.peer_key = pkey;
        r.region_ok = ok;
        return r;
    endfunction

    // half below one chunk, some on chunk boundaries, some spanning up to eight chunks, a few up to full size
    function automatic logic [LEN_W-1:0] pick_len();
        int roll;
        roll = $urandom_range(99);
        if (roll < 50) return LEN_W'($urandom) & ((LEN_W'(1) << $urandom_range(30)) - 1);
        if (roll < 70) begin
            case ($urandom_range(6))
                0: return '0;
                1: return LEN_W'(1);
                2: return CHUNK - 1;
                3: return CHUNK;
                4: return CHUNK + 1;
                5: return CHUNK * 2;
                default: return CHUNK * 3 - 1;
            endcase
        end
        if (roll < 95) return (LEN_W'($urandom_range(7)) << CHUNK_LOG2_DEF) | LEN_W'($urandom)
                              & (CHUNK - 1);
        case ($urandom_range(2))
            0: return MAX_LEN;
            1: return MAX_LEN - 1;
            default: return LEN_W'(rand64()) & (MAX_LEN - 1);
        endcase
    endfunction

    function automatic t_in_req noise_req();
        return req_of(3'($urandom_range(7)), rand64(), $urandom,
                      $urandom_range(1) ? pick_len() : LEN_W'(rand64()),
                      rand64(), rand64(), $urandom, 1'($urandom));
    endfunction

    function automatic t_in_req ctl_req(input t_func func);
        t_in_req r;
        r = noise_req();
        r.func = func;
        return r;
    endfunction

    function automatic t_in_req insert_req();
        t_in_req r;
        r = ctl_req(FUNC_INSERT);
        r.buffer_size = pick_len();
        return r;
    endfunction

    function automatic t_in_req reply_req(input logic [ADDR_W-1:0] psize, input logic ok);
        t_in_req r;
        r = ctl_req(FUNC_REPLY);
        r.peer_size = psize;
        r.region_ok = ok;
        return r;
    endfunction

    task automatic pick_request(output t_in_req req);
        int roll;
        logic [ADDR_W-1:0] psize;
        roll = $urandom_range(99);
        if (burst_left > 0) begin
            burst_left--;
            req = insert_req();
        end else if (roll < 12) begin
            req = noise_req();
        end else if (mon_entries == 0 || (roll < 24 && mon_entries < QUEUE_DEPTH_DEF)) begin
            if ($urandom_range(99) < 4) burst_left = $urandom_range(20, 12);
            req = insert_req();
        end else if (roll < 26) begin
            req = ctl_req(FUNC_OPEN_DONE);
        end else begin
            roll = $urandom_range(99);
            case (mon_phase)
                PH_SEND: begin
                    psize = rand64();
                    if (psize < head_len) psize = head_len + $urandom_range(3);
                    if (roll < 25) psize = head_len;
                    if (roll < 70) req = reply_req(psize, 1'b1);
                    else if (roll < 80) req = reply_req(psize, 1'b0);
                    else if (roll < 88) req = ctl_req(FUNC_REFUSE);
                    else if (roll < 95 && head_len != 0)
                        req = reply_req(head_len - 1, 1'($urandom));
                    else req = noise_req();
                end
                PH_RDMA:  req = (roll < 95) ? ctl_req(FUNC_WRITE_DONE) : noise_req();
                PH_CLOSE: req = ctl_req(FUNC_CLOSE_DONE);
                PH_FAIL:  req = ctl_req(FUNC_FAIL_DONE);
                default:  req = noise_req();
            endcase
        end
    endtask

    task automatic send_request(input t_in_req req);
        @(negedge i_clk);
        if ($urandom_range(99) < snd_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(negedge i_clk); while ($urandom_range(99) < snd_idle_pct);
        end
        i_in_valid <= 1'b1;
        i_in_data <= req;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    task automatic write_regs(input logic [15:0] rank, input logic [31:0] tag);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= CFG_PEER_RANK;
        i_cfg_data <= {16'($urandom), rank};
        @(negedge i_clk);
        i_cfg_index <= CFG_MESSAGE_TAG;
        i_cfg_data <= tag;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    initial begin : stimulus
        t_in_req req;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        i_out_ready = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = CFG_PEER_RANK;
        i_cfg_data = '0;
        burst_left = 0;
        sent = 0;
        snd_idle_pct = 32;
        rcv_idle_pct = 50;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        write_regs(16'hFFFF, 32'h0);

        // events on an empty queue, ignored requests, oversize inserts
        send_request(ctl_req(FUNC_REPLY));
        send_request(ctl_req(FUNC_REFUSE));
        send_request(ctl_req(FUNC_CLOSE_DONE));
        send_request(ctl_req(FUNC_FAIL_DONE));
        send_request(ctl_req(FUNC_WRITE_DONE));
        send_request(ctl_req(FUNC_OPEN_DONE));
        req = noise_req();
        req.func = FUNC_UNUSED;
        send_request(req);
        send_request(req_of(FUNC_INSERT, '0, '0, '1, '0, '0, '0, 1'b0));
        send_request(req_of(FUNC_INSERT, '0, '0, MAX_LEN + 1, '0, '0, '0, 1'b0));
        // two chunks with both addresses wrapping
        send_request(req_of(FUNC_INSERT, ALL_ONES - 15, '1, CHUNK + 5, '0, '0, '0, 1'b0));
        send_request(req_of(FUNC_INSERT, '0, '0, '0, '0, '0, '0, 1'b0));
        send_request(ctl_req(FUNC_CLOSE_DONE));
        send_request(ctl_req(FUNC_WRITE_DONE));
        send_request(req_of(FUNC_REPLY, '0, '0, '0, ALL_ONES - 255, CHUNK + 4, '1, 1'b1));
        send_request(req_of(FUNC_REPLY, '0, '0, '0, ALL_ONES - 255, CHUNK + 5, '1, 1'b1));
        send_request(ctl_req(FUNC_REPLY));
        send_request(ctl_req(FUNC_WRITE_DONE));
        send_request(ctl_req(FUNC_WRITE_DONE));
        send_request(ctl_req(FUNC_CLOSE_DONE));
        // zero-size buffer still gets one write
        send_request(req_of(FUNC_REPLY, '0, '0, '0, rand64(), '0, '0, 1'b1));
        send_request(ctl_req(FUNC_WRITE_DONE));
        send_request(ctl_req(FUNC_CLOSE_DONE));
        send_request(req_of(FUNC_INSERT, rand64(), $urandom, MAX_LEN, '0, '0, '0, 1'b0));
        send_request(req_of(FUNC_REPLY, '0, '0, '0, rand64(), ALL_ONES, $urandom, 1'b0));
        send_request(ctl_req(FUNC_FAIL_DONE));
        send_request(insert_req());
        send_request(ctl_req(FUNC_REFUSE));

        for (int stage = 0; stage < 3; stage++) begin
            if (stage == 1) begin
                drain();
                write_regs(16'h0000, 32'hFFFF_FFFF);
                snd_idle_pct = 50;
                rcv_idle_pct = 32;
            end else if (stage == 2) begin
                drain();
                write_regs(16'($urandom), $urandom);
                snd_idle_pct = 0;
                rcv_idle_pct = 0;
            end
            while (sent < (stage + 1) * RANDOM_ITEMS / 3) begin
                pick_request(req);
                send_request(req);
                sent++;
            end
        end

        drain();
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
